// ===== rtl/assert_macros.svh =====
// assertion helpers, included by the keypad decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property violated");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/kpd_pkg.sv =====
`default_nettype none

package kpd_pkg;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_e;

  localparam logic [1:0] MODE_CALC = 2'd0;
  localparam logic [1:0] MODE_LOCK = 2'd1;

  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_QUIT = 8'hFF;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LP    = 8'h70;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
  } row_hit_t;

  typedef struct packed {
    logic [7:0] key_code;
    act_e       action;
    logic [7:0] append_char;
  } kpd_res_t;

  // exactly one row bit set gives a hit
  function automatic row_hit_t one_hot_row(input logic [3:0] rows);
    row_hit_t r;
    r = '{hit: 1'b1, row: 2'd0};
    case (rows)
      4'b0001: r.row = 2'd0;
      4'b0010: r.row = 2'd1;
      4'b0100: r.row = 2'd2;
      4'b1000: r.row = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // shifted key table, page 3 falls back to page 0
  function automatic logic [7:0] shift_char(input logic [1:0] page, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_A;
    case (page)
      2'd1: begin
        case (idx)
          3'd1:    c = CH_STAR;
          3'd2:    c = CH_SLASH;
          3'd3:    c = CH_N;
          3'd4:    c = CH_P;
          3'd5:    c = CH_R;
          default: c = CH_A;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd1:    c = CH_LE;
          3'd2:    c = CH_L;
          3'd3:    c = CH_K;
          3'd4:    c = CH_LPAR;
          3'd5:    c = CH_RPAR;
          default: c = CH_A;
        endcase
      end
      default: begin
        case (idx)
          3'd1:    c = CH_PLUS;
          3'd2:    c = CH_MINUS;
          3'd3:    c = CH_EQ;
          3'd4:    c = CH_DOT;
          3'd5:    c = CH_Z;
          default: c = CH_A;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kpd_scan.sv =====
`default_nettype none

module kpd_scan
  import kpd_pkg::*;
(
  input  logic [3:0] rows_col1_i,
  input  logic [3:0] rows_col2_i,
  input  logic [3:0] rows_col3_i,
  input  logic [3:0] rows_col4_i,
  input  logic [1:0] shift_page_i,
  output logic [7:0] key_o
);

  row_hit_t h1, h2, h3, h4;

  assign h1 = one_hot_row(rows_col1_i);
  assign h2 = one_hot_row(rows_col2_i);
  assign h3 = one_hot_row(rows_col3_i);
  assign h4 = one_hot_row(rows_col4_i);

  // first column with a clean single press wins
  always_comb begin
    key_o = KEY_NONE;
    if (h1.hit) begin
      case (h1.row)
        2'd0:    key_o = CH_1;
        2'd1:    key_o = CH_4;
        2'd2:    key_o = CH_7;
        default: key_o = shift_char(shift_page_i, 3'd4);
      endcase
    end else if (h2.hit) begin
      case (h2.row)
        2'd0:    key_o = CH_2;
        2'd1:    key_o = CH_5;
        2'd2:    key_o = CH_8;
        default: key_o = CH_0;
      endcase
    end else if (h3.hit) begin
      case (h3.row)
        2'd0:    key_o = CH_3;
        2'd1:    key_o = CH_6;
        2'd2:    key_o = CH_9;
        default: key_o = shift_char(shift_page_i, 3'd5);
      endcase
    end else if (h4.hit) begin
      key_o = shift_char(shift_page_i, {1'b0, h4.row});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kpd_cmd.sv =====
`default_nettype none

module kpd_cmd
  import kpd_pkg::*;
(
  input  logic [7:0] key_i,
  input  logic [7:0] last_key_i,
  input  logic       result_page_i,
  input  logic [1:0] mode_i,
  output kpd_res_t   res_o
);

  logic       calc;
  logic [7:0] key;

  assign calc = (mode_i == MODE_CALC);

  always_comb begin
    res_o = '{key_code: KEY_NONE, action: ACT_NONE, append_char: 8'h00};
    key   = key_i;
    // debounce: only a key seen twice in a row counts
    if (key_i == last_key_i) begin
      if (result_page_i && key_i != KEY_NONE) begin
        key = KEY_QUIT;
      end
      case (key)
        CH_Z: begin
          if (calc) res_o.action = ACT_DELETE;
        end
        CH_N: begin
          if (calc) res_o = '{key_code: key, action: ACT_APPEND, append_char: CH_LA};
        end
        CH_P: begin
          if (calc) res_o = '{key_code: key, action: ACT_APPEND, append_char: CH_LP};
        end
        CH_L: begin
          if (calc) res_o = '{key_code: key, action: ACT_APPEND, append_char: CH_LL};
        end
        KEY_QUIT, CH_R: begin
          res_o.action = ACT_CLEAR;
        end
        CH_K, KEY_NONE, CH_A, CH_EQ: begin
        end
        default: begin
          if (calc) begin
            res_o.action      = ACT_APPEND;
            res_o.append_char = key;
          end else if (key inside {CH_PLUS, CH_STAR, CH_LE}) begin
            key = CH_B;
          end
        end
      endcase
      if (mode_i == MODE_LOCK && key inside {CH_EQ, CH_N, CH_K}) begin
        key = CH_EQ;
      end
      res_o.key_code = key;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/keypad_scan_debounce_decoder_core.sv =====
// keypad scan decoder with two-scan debounce
// in channel: in_valid_i / in_ready_o carry one full 4x4 scan (four row codes,
//   one per driven column) plus shift page, result-page flag and mode
// out channel: out_valid_o / out_ready_i carry one result per scan: key code,
//   buffer command and the character to append
// path: a taken scan is held in the input register, decoded from it and
//   loaded into the result register, which drives the outputs
// throughput: one scan per cycle while out_ready_i is high; the decode
//   and previous-key compare sit in one combinational pass between registers
// stall: when the receiver holds out_ready_i low, the result register keeps
//   its item and the input register fills; in_ready_o drops only when both
//   hold an item, and no transfer is lost or repeated
// reset: rst_ni clears both valid flags and the stored previous key, so the
//   first scan after reset compares against "no key"
`default_nettype none
`include "assert_macros.svh"

module keypad_scan_debounce_decoder_core
  import kpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] rows_col1_i,
  input  logic [3:0] rows_col2_i,
  input  logic [3:0] rows_col3_i,
  input  logic [3:0] rows_col4_i,
  input  logic [1:0] shift_page_i,
  input  logic       result_page_i,
  input  logic [1:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] key_code_o,
  output logic [1:0] buffer_action_o,
  output logic [7:0] append_char_o
);

  logic       s1_valid_q;
  logic [3:0] s1_col1_q, s1_col2_q, s1_col3_q, s1_col4_q;
  logic [1:0] s1_page_q;
  logic       s1_rp_q;
  logic [1:0] s1_mode_q;

  logic       out_valid_q;
  kpd_res_t   out_res_q;
  logic [7:0] last_key_q;

  logic       out_free;
  logic       s1_adv;
  logic       in_xfer;
  logic [7:0] raw_key;
  kpd_res_t   res_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  kpd_scan u_scan (
    .rows_col1_i  (s1_col1_q),
    .rows_col2_i  (s1_col2_q),
    .rows_col3_i  (s1_col3_q),
    .rows_col4_i  (s1_col4_q),
    .shift_page_i (s1_page_q),
    .key_o        (raw_key)
  );

  kpd_cmd u_cmd (
    .key_i         (raw_key),
    .last_key_i    (last_key_q),
    .result_page_i (s1_rp_q),
    .mode_i        (s1_mode_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_key_q  <= KEY_NONE;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= s1_valid_q;
      // previous key always ends up equal to the scan just decoded
      if (s1_adv) last_key_q <= raw_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_col1_q <= rows_col1_i;
      s1_col2_q <= rows_col2_i;
      s1_col3_q <= rows_col3_i;
      s1_col4_q <= rows_col4_i;
      s1_page_q <= shift_page_i;
      s1_rp_q   <= result_page_i;
      s1_mode_q <= mode_i;
    end
    if (s1_adv) out_res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign key_code_o      = out_res_q.key_code;
  assign buffer_action_o = out_res_q.action;
  assign append_char_o   = out_res_q.append_char;

  `ASSERT_NEVER(a_char_only_on_append, clk_i, rst_ni,
                out_valid_o && buffer_action_o != ACT_APPEND && append_char_o != 8'h00)
  `ASSERT_NEVER(a_no_key_no_action, clk_i, rst_ni,
                out_valid_o && key_code_o == KEY_NONE && buffer_action_o != ACT_NONE)
  `ASSERT_PROP(a_quit_clears, clk_i, rst_ni,
               out_valid_o && key_code_o == KEY_QUIT |-> buffer_action_o == ACT_CLEAR)
  `ASSERT_PROP(a_last_key_holds, clk_i, rst_ni,
               !s1_adv |=> $stable(last_key_q))
  `ASSERT_PROP(a_stall_holds_result, clk_i, rst_ni,
               out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_res_q))

endmodule

`default_nettype wire
